FILE: design/ags_pkg.sv
// Shared constants, types and controller/datapath command and status structs for the argsort block.
package ags_pkg;

  localparam int MAX_ITEMS   = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int INDEX_WIDTH = 6;
  localparam int COUNT_WIDTH = $clog2(MAX_ITEMS + 1);

  typedef logic signed [VALUE_WIDTH-1:0] value_t;
  typedef logic [INDEX_WIDTH-1:0]        index_t;
  typedef logic [COUNT_WIDTH-1:0]        count_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;   // store the transferred element in its sorted place
    logic drop;     // element arrived with the chain full
    logic shift;    // result transferred, advance the chain toward cell 0
  } ags_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic full;
    logic one_left;
    logic empty;
  } ags_status_t;

endpackage

FILE: design/ags_in_if.sv
// Input channel interface: one element of the set per transfer.
interface ags_in_if;
  logic                  valid;
  logic                  ready;
  ags_pkg::value_t       value;
  logic                  last;

  modport source (output valid, value, last, input ready);
  modport sink   (input valid, value, last, output ready);
endinterface

FILE: design/ags_out_if.sv
// Result channel interface: one sorted element with its arrival index per transfer.
interface ags_out_if;
  logic                  valid;
  logic                  ready;
  ags_pkg::value_t       sorted_value;
  ags_pkg::index_t       original_index;
  logic                  overflow;
  logic                  last_out;

  modport source (output valid, sorted_value, original_index, overflow, last_out, input ready);
  modport sink   (input valid, sorted_value, original_index, overflow, last_out, output ready);
endinterface

FILE: design/ags_datapath.sv
// Systolic insertion chain holding the sorted elements, element count and overflow flag.
module ags_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ags_pkg::ags_cmd_t     cmd,
  input  ags_pkg::value_t       in_value,
  output ags_pkg::ags_status_t  status,
  output ags_pkg::value_t       out_sorted_value,
  output ags_pkg::index_t       out_original_index,
  output logic                  out_overflow,
  output logic                  out_last_out
);
  import ags_pkg::*;

  value_t val_r [MAX_ITEMS];
  index_t idx_r [MAX_ITEMS];
  count_t count_r, count_nxt;
  logic   ovf_r, ovf_nxt;
  logic   gt [MAX_ITEMS];
  index_t arrival;

  assign arrival = index_t'(count_r);

  // Empty cells count as larger than any element; the strict compare keeps ties in arrival order.
  always_comb begin
    for (int i = 0; i < MAX_ITEMS; i++) begin
      gt[i] = (count_r <= COUNT_WIDTH'(i)) || (val_r[i] > in_value);
    end
  end

  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    always_ff @(posedge clk) begin
      if (cmd.insert) begin
        if (gt[i]) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            val_r[i] <= val_r[(i > 0) ? i - 1 : 0];
            idx_r[i] <= idx_r[(i > 0) ? i - 1 : 0];
          end else begin
            val_r[i] <= in_value;
            idx_r[i] <= arrival;
          end
        end
      end else if (cmd.shift && i < MAX_ITEMS - 1) begin
        val_r[i] <= val_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
        idx_r[i] <= idx_r[(i < MAX_ITEMS - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (cmd.insert) begin
      count_nxt = count_r + count_t'(1);
    end else if (cmd.drop) begin
      ovf_nxt = 1'b1;
    end else if (cmd.shift) begin
      count_nxt = count_r - count_t'(1);
      // final result of the set: clear for the next one
      if (status.one_left) begin
        ovf_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  assign status.full     = (count_r == COUNT_WIDTH'(MAX_ITEMS));
  assign status.one_left = (count_r == count_t'(1));
  assign status.empty    = (count_r == '0);

  assign out_sorted_value   = val_r[0];
  assign out_original_index = idx_r[0];
  assign out_overflow       = ovf_r;
  assign out_last_out       = status.one_left;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_WIDTH'(MAX_ITEMS))
    else $error("element count beyond chain depth");

  a_drop_sets_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.drop |=> ovf_r)
    else $error("dropped element did not set overflow");

  a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.shift && status.one_left) |=> (count_r == '0 && !ovf_r))
    else $error("set not cleared after final result");

endmodule

FILE: design/ags_ctrl.sv
// Controller: load phase takes elements, emit phase hands out the sorted results.
module ags_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_last,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  ags_pkg::ags_status_t  status,
  output ags_pkg::ags_cmd_t     cmd
);
  import ags_pkg::*;

  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   in_xfer, out_xfer;

  assign in_ready  = (state_r == ST_LOAD);
  assign out_valid = (state_r == ST_EMIT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  assign cmd.insert = in_xfer && !status.full;
  assign cmd.drop   = in_xfer && status.full;
  assign cmd.shift  = out_xfer;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: if (in_xfer && in_last) begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: if (out_xfer && status.one_left) begin
        state_nxt = ST_LOAD;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_phase_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("load and emit phases overlap");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !status.empty)
    else $error("emitting from an empty chain");

  a_close_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_last) |=> out_valid)
    else $error("closing element did not start emit phase");

endmodule

FILE: design/argsort_with_indices.sv
// Top level of the stable argsort block: controller plus insertion chain.
//
// Elements are taken one per cycle while loading; each lands in its sorted
// place in a 64-cell insertion chain in the cycle it transfers. The element
// flagged last closes the set, and the block then hands out the n stored
// elements one per cycle while the receiver is ready, in ascending order
// (ties in arrival order), each with its arrival index. No input is taken
// during the emit phase. Elements beyond 64 are dropped and every result
// of that set carries overflow. No clearing pass is needed after reset.
module argsort_with_indices (
  input  logic      clk,
  input  logic      rst_n,
  ags_in_if.sink    in_ch,
  ags_out_if.source out_ch
);
  import ags_pkg::*;

  ags_cmd_t    cmd;
  ags_status_t status;

  ags_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_last   (in_ch.last),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  ags_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_value           (in_ch.value),
    .status             (status),
    .out_sorted_value   (out_ch.sorted_value),
    .out_original_index (out_ch.original_index),
    .out_overflow       (out_ch.overflow),
    .out_last_out       (out_ch.last_out)
  );

endmodule
